// ===== hw/rtl/ascr_pkg.sv =====
// ----------------------------------------------------------------------------
// ascr_pkg
// Shared constants and types of the angle sensor command responder: sensor
// count, angle width, host protocol codes and the state machine encodings.
// ----------------------------------------------------------------------------
package ascr_pkg;

  // Number of sensors and width of a raw angle.
  localparam int NUM_SENSORS = 6;
  localparam int ANGLE_BITS  = 14;

  // Width of a sensor index into the per-sensor memories.
  localparam int SENS_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  // Host protocol codes.
  localparam logic [7:0] START_MARK   = 8'hAA;
  localparam logic [7:0] OP_CALIBRATE = 8'h01;
  localparam logic [7:0] OP_READ      = 8'h02;

  // Host frame decoder phase.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMD  = 2'd1,
    PH_SUM  = 2'd2
  } phase_t;

  // Command sequencer state.
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_CAL,
    SQ_RD_HI,
    SQ_RD_LO,
    SQ_RD_ERR,
    SQ_RD_SUM
  } seq_state_t;

  // Commands decoded from a complete host frame.
  typedef struct packed {
    logic cal_go;
    logic rd_go;
  } frame_go_t;

endpackage

// ===== hw/rtl/ascr_ram.sv =====
// ----------------------------------------------------------------------------
// ascr_ram
// Small single-write, single-read memory with a registered read port. Each
// entry has a valid bit cleared by reset; an entry never written reads zero.
// ----------------------------------------------------------------------------
module ascr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits stand for the all-zero reset contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= valid_r[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

// ===== hw/rtl/ascr_framer.sv =====
// ----------------------------------------------------------------------------
// ascr_framer
// Host frame decoder: start byte, command byte, checksum byte equal to the
// command. Flags a valid calibrate or read frame on its checksum transfer.
// ----------------------------------------------------------------------------
module ascr_framer
  import ascr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       host_xfer,
  input  logic [7:0] rx_byte,
  output frame_go_t  go
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_command_r, held_command_nxt;

  // Next phase and held command.
  always_comb begin
    phase_nxt        = phase_r;
    held_command_nxt = held_command_r;
    if (host_xfer) begin
      unique case (phase_r)
        PH_CMD: begin
          held_command_nxt = rx_byte;
          phase_nxt        = PH_SUM;
        end
        PH_SUM: begin
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = (rx_byte == START_MARK) ? PH_CMD : PH_IDLE;
        end
      endcase
    end
  end

  // Command strobes on a checksum that matches a known command.
  always_comb begin
    go = '0;
    unique case (phase_r)
      PH_SUM: begin
        if (host_xfer && (rx_byte == held_command_r)) begin
          go.cal_go = (held_command_r == OP_CALIBRATE);
          go.rd_go  = (held_command_r == OP_READ);
        end
      end
      default: begin
        go = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      held_command_r <= '0;
    end else begin
      phase_r        <= phase_nxt;
      held_command_r <= held_command_nxt;
    end
  end

endmodule

// ===== hw/rtl/angle_sensor_command_responder_core.sv =====
// ----------------------------------------------------------------------------
// angle_sensor_command_responder_core
// Stores sensor angles and offsets in two small memories and answers host
// calibrate and read frames by scanning them one sensor at a time.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                        | Transfer
//  ---------+----------------------------------------------+----------------------
//  input    | in_cmd in_rx_byte in_sensor_index in_angle    | start high, busy low
//           | in_read_failed                               |
//  result   | out_tx_byte out_last                          | out_valid, one cycle
//
// A sensor reading or a host byte that completes no command leaves busy low.
// A calibrate frame holds busy for one memory read and offset write per
// sensor. A read frame holds busy while it builds its packet; its bytes come
// one per cycle starting the cycle after the checksum
// transfer, paced by the angle and offset memory read ports.
// Reset is synchronous; memory contents read as zero until written. The
// receiver cannot stall the result stream.
// ----------------------------------------------------------------------------
module angle_sensor_command_responder_core
  import ascr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_cmd,
  input  logic [7:0]            in_rx_byte,
  input  logic [2:0]            in_sensor_index,
  input  logic [ANGLE_BITS-1:0] in_angle,
  input  logic                  in_read_failed,
  output logic                  out_valid,
  output logic [7:0]            out_tx_byte,
  output logic                  out_last
);

  seq_state_t             state_r, state_nxt;
  logic [SENS_W-1:0]      cnt_r, cnt_nxt;
  logic [7:0]             sum_r, sum_nxt;
  logic [7:0]             lo_r, lo_nxt;
  logic [NUM_SENSORS-1:0] err_r, err_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_tx_byte_r, out_tx_byte_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   xfer;
  logic                   cnt_end;
  frame_go_t              frm;

  logic                   ang_we;
  logic [ANGLE_BITS:0]    ang_wdata;
  logic [ANGLE_BITS:0]    ang_rdata;
  logic                   off_we;
  logic [ANGLE_BITS-1:0]  off_wdata;
  logic [ANGLE_BITS-1:0]  off_rdata;
  logic [SENS_W-1:0]      rd_addr;
  logic [SENS_W-1:0]      ang_waddr;
  logic [15:0]            diff;

  assign xfer    = start && !busy;
  assign cnt_end = (cnt_r == SENS_W'(NUM_SENSORS - 1));
  assign diff    = 16'(ang_rdata[ANGLE_BITS-1:0]) - 16'(off_rdata);
  assign ang_waddr = in_sensor_index[SENS_W-1:0];

  // Host frame decoding.
  ascr_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .host_xfer (xfer && !in_cmd),
    .rx_byte   (in_rx_byte),
    .go        (frm)
  );

  // Per-sensor {last read failed, angle}.
  ascr_ram #(
    .WIDTH (ANGLE_BITS + 1),
    .DEPTH (NUM_SENSORS)
  ) u_angle_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ang_we),
    .wr_addr (ang_waddr),
    .wr_data (ang_wdata),
    .rd_addr (rd_addr),
    .rd_data (ang_rdata)
  );

  // Per-sensor calibration offset.
  ascr_ram #(
    .WIDTH (ANGLE_BITS),
    .DEPTH (NUM_SENSORS)
  ) u_offset_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (off_we),
    .wr_addr (cnt_r),
    .wr_data (off_wdata),
    .rd_addr (rd_addr),
    .rd_data (off_rdata)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (frm.cal_go) begin
          state_nxt = SQ_CAL;
        end else if (frm.rd_go) begin
          state_nxt = SQ_RD_HI;
        end
      end
      SQ_CAL: begin
        if (cnt_end) begin
          state_nxt = SQ_IDLE;
        end
      end
      SQ_RD_HI:  state_nxt = SQ_RD_LO;
      SQ_RD_LO:  state_nxt = cnt_end ? SQ_RD_ERR : SQ_RD_HI;
      SQ_RD_ERR: state_nxt = SQ_RD_SUM;
      SQ_RD_SUM: state_nxt = SQ_IDLE;
      default:   state_nxt = SQ_IDLE;
    endcase
  end

  // Sequencer datapath, memory accesses and result bytes.
  always_comb begin
    cnt_nxt         = cnt_r;
    sum_nxt         = sum_r;
    lo_nxt          = lo_r;
    err_nxt         = err_r;
    out_valid_nxt   = 1'b0;
    out_tx_byte_nxt = '0;
    out_last_nxt    = 1'b0;
    ang_we          = 1'b0;
    ang_wdata       = '0;
    off_we          = 1'b0;
    off_wdata       = '0;
    rd_addr         = '0;
    unique case (state_r)
      SQ_IDLE: begin
        // Sensor reading; indexes beyond the sensor count are dropped.
        if (xfer && in_cmd && ({1'b0, in_sensor_index} < 4'(NUM_SENSORS))) begin
          ang_we = 1'b1;
          if (in_read_failed) begin
            ang_wdata = {1'b1, {ANGLE_BITS{1'b0}}};
            for (int i = 0; i < NUM_SENSORS; i++) begin
              if (in_sensor_index == 3'(i)) begin
                err_nxt[i] = 1'b1;
              end
            end
          end else begin
            ang_wdata = {1'b0, in_angle};
          end
        end
        // Command start: sensor 0 is addressed now, its data lands next cycle.
        if (frm.cal_go || frm.rd_go) begin
          cnt_nxt = '0;
          sum_nxt = '0;
        end
        if (frm.rd_go) begin
          out_valid_nxt   = 1'b1;
          out_tx_byte_nxt = START_MARK;
        end
      end
      SQ_CAL: begin
        // Copy the stored angle into the offset, or zero the offset and flag a failed sensor.
        off_we = 1'b1;
        if (ang_rdata[ANGLE_BITS]) begin
          off_wdata = '0;
          for (int i = 0; i < NUM_SENSORS; i++) begin
            if (cnt_r == SENS_W'(i)) begin
              err_nxt[i] = 1'b1;
            end
          end
        end else begin
          off_wdata = ang_rdata[ANGLE_BITS-1:0];
        end
        cnt_nxt = cnt_r + 1'b1;
        rd_addr = cnt_r + 1'b1;
      end
      SQ_RD_HI: begin
        out_valid_nxt   = 1'b1;
        out_tx_byte_nxt = diff[15:8];
        lo_nxt          = diff[7:0];
        sum_nxt         = sum_r + diff[15:8];
      end
      SQ_RD_LO: begin
        out_valid_nxt   = 1'b1;
        out_tx_byte_nxt = lo_r;
        sum_nxt         = sum_r + lo_r;
        cnt_nxt         = cnt_r + 1'b1;
        rd_addr         = cnt_r + 1'b1;
      end
      SQ_RD_ERR: begin
        out_valid_nxt   = 1'b1;
        out_tx_byte_nxt = 8'(err_r);
        sum_nxt         = sum_r + 8'(err_r);
      end
      SQ_RD_SUM: begin
        out_valid_nxt   = 1'b1;
        out_tx_byte_nxt = sum_r;
        out_last_nxt    = 1'b1;
        err_nxt         = '0;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_IDLE;
      err_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt_r         <= cnt_nxt;
    sum_r         <= sum_nxt;
    lo_r          <= lo_nxt;
    out_tx_byte_r <= out_tx_byte_nxt;
  end

  assign busy        = (state_r != SQ_IDLE);
  assign out_valid   = out_valid_r;
  assign out_tx_byte = out_tx_byte_r;
  assign out_last    = out_last_r;

  // The checksum byte ends a packet; nothing follows it in the next cycle.
  a_last_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result transfer right after a packet checksum");

  // The final read state always delivers the checksum byte.
  a_sum_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SQ_RD_SUM |=> out_valid && out_last)
    else $error("read sequence ended without a checksum byte");

  // The framer never starts two commands at once.
  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    !(frm.cal_go && frm.rd_go))
    else $error("calibrate and read started together");

  // No sensor write lands while a command scans the memories.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !ang_we)
    else $error("angle memory written during a command scan");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for angle_sensor_command_responder_core. It drives
// sensor readings and host frames (read, calibrate, broken frames and line
// noise) in random bursts. A scoreboard keeps its own copy of the angles,
// offsets and error flags, predicts each response packet, and compares every
// byte the block sends.
// ----------------------------------------------------------------------------
module tb
  import ascr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 7;
  localparam int TOTAL_ITEMS    = 370;
  localparam int QUIET_LIMIT    = 1000;
  localparam int DRAIN_CYCLES   = 2 * NUM_SENSORS + 8;

  // One byte of a response packet.
  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } tx_beat_t;

  // Predicts the response packets and checks the bytes that come back.
  class responder_scoreboard;
    logic [ANGLE_BITS-1:0]  stored_angle[NUM_SENSORS];
    logic [ANGLE_BITS-1:0]  cal_offset[NUM_SENSORS];
    logic                   read_bad[NUM_SENSORS];
    logic [NUM_SENSORS-1:0] error_flags;
    phase_t                 framer;
    logic [7:0]             cmd_byte;
    tx_beat_t               packet_bytes[$];
    int                     fail_count;

    function new();
      for (int i = 0; i < NUM_SENSORS; i++) begin
        stored_angle[i] = '0;
        cal_offset[i]   = '0;
        read_bad[i]     = 1'b0;
      end
      error_flags = '0;
      framer      = PH_IDLE;
      cmd_byte    = '0;
      fail_count  = 0;
    endfunction

    function void push_byte(logic [7:0] b, logic fin);
      tx_beat_t beat;
      beat.tx   = b;
      beat.last = fin;
      packet_bytes.push_back(beat);
    endfunction

    // Builds the whole read response and clears the error flags.
    function void build_read_packet();
      logic [15:0] diff;
      logic [7:0]  sum;
      sum = '0;
      push_byte(START_MARK, 1'b0);
      for (int i = 0; i < NUM_SENSORS; i++) begin
        diff = 16'(stored_angle[i]) - 16'(cal_offset[i]);
        sum  = sum + diff[15:8] + diff[7:0];
        push_byte(diff[15:8], 1'b0);
        push_byte(diff[7:0], 1'b0);
      end
      sum = sum + 8'(error_flags);
      push_byte(8'(error_flags), 1'b0);
      push_byte(sum, 1'b1);
      error_flags = '0;
    endfunction

    // Updates the state for one input transfer.
    function void note_transfer(logic c, logic [7:0] rx, logic [2:0] idx,
                                logic [ANGLE_BITS-1:0] ang, logic bad);
      if (c) begin
        // A reading for a sensor that does not exist changes nothing.
        if (int'(idx) < NUM_SENSORS) begin
          if (bad) begin
            stored_angle[idx] = '0;
            read_bad[idx]     = 1'b1;
            error_flags[idx]  = 1'b1;
          end else begin
            stored_angle[idx] = ang;
            read_bad[idx]     = 1'b0;
          end
        end
        return;
      end
      case (framer)
        PH_CMD: begin
          cmd_byte = rx;
          framer   = PH_SUM;
        end
        PH_SUM: begin
          framer = PH_IDLE;
          if (rx == cmd_byte) begin
            if (cmd_byte == OP_CALIBRATE) begin
              // A sensor whose last read failed gets offset zero and its flag.
              for (int i = 0; i < NUM_SENSORS; i++) begin
                if (read_bad[i]) begin
                  error_flags[i] = 1'b1;
                  cal_offset[i]  = '0;
                end else begin
                  cal_offset[i] = stored_angle[i];
                end
              end
            end else if (cmd_byte == OP_READ) begin
              build_read_packet();
            end
          end
        end
        default: begin
          framer = (rx == START_MARK) ? PH_CMD : PH_IDLE;
        end
      endcase
    endfunction

    // Compares one sent byte with the oldest predicted one.
    function void check_byte(logic [7:0] b, logic fin);
      tx_beat_t want;
      if (packet_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual tx_byte %02h last %0b",
                 $time, b, fin);
        fail_count++;
        return;
      end
      want = packet_bytes.pop_front();
      if (b !== want.tx) begin
        $display("%0t: tx_byte mismatch, expected %02h, actual %02h", $time, want.tx, b);
        fail_count++;
      end
      if (fin !== want.last) begin
        $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.last, fin);
        fail_count++;
      end
    endfunction

    function int pending();
      return packet_bytes.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_cmd;
  logic [7:0]            in_rx_byte;
  logic [2:0]            in_sensor_index;
  logic [ANGLE_BITS-1:0] in_angle;
  logic                  in_read_failed;
  logic                  out_valid;
  logic [7:0]            out_tx_byte;
  logic                  out_last;

  responder_scoreboard sb;
  int                  items_sent;
  int                  burst_left;
  int                  quiet_cycles;

  angle_sensor_command_responder_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_rx_byte      (in_rx_byte),
    .in_sensor_index (in_sensor_index),
    .in_angle        (in_angle),
    .in_read_failed  (in_read_failed),
    .out_valid       (out_valid),
    .out_tx_byte     (out_tx_byte),
    .out_last        (out_last)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Watch both channels at the rising edge and count cycles with no transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        sb.check_byte(out_tx_byte, out_last);
      end
      if (start && !busy) begin
        sb.note_transfer(in_cmd, in_rx_byte, in_sensor_index, in_angle, in_read_failed);
      end
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // End the run if the block stops moving.
  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAIL angle_sensor_command_responder_core");
    $finish;
  end

  // Drops start and puts junk on the payload for a gap set by n.
  task automatic idle_gap(input int n);
    @(negedge clk);
    start           = 1'b0;
    in_cmd          = 1'($urandom);
    in_rx_byte      = 8'($urandom);
    in_sensor_index = 3'($urandom);
    in_angle        = ANGLE_BITS'($urandom);
    in_read_failed  = 1'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  // Sender bursts: a random run of back-to-back transfers, then a gap.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_gap($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(0, 8);
    end
  endtask

  // Presents one item and holds it until the block takes the transfer.
  task automatic send_item(input logic c, input logic [7:0] rx, input logic [2:0] idx,
                           input logic [ANGLE_BITS-1:0] ang, input logic bad);
    @(negedge clk);
    start           = 1'b1;
    in_cmd          = c;
    in_rx_byte      = rx;
    in_sensor_index = idx;
    in_angle        = ang;
    in_read_failed  = bad;
    do @(posedge clk); while (busy);
    items_sent++;
    pace();
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(1'b0, b, 3'($urandom), ANGLE_BITS'($urandom), 1'($urandom));
  endtask

  task automatic send_reading(input logic [2:0] idx, input logic [ANGLE_BITS-1:0] ang,
                              input logic bad);
    send_item(1'b1, 8'($urandom), idx, ang, bad);
  endtask

  task automatic send_frame(input logic [7:0] op, input logic [7:0] check);
    send_byte(START_MARK);
    send_byte(op);
    send_byte(check);
  endtask

  // Holds the sender off until every predicted byte has been sent.
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Random reading, mostly for real sensors, with extreme angles now and then.
  task automatic random_reading();
    logic [2:0]            idx;
    logic [ANGLE_BITS-1:0] ang;
    idx = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(NUM_SENSORS, 7))
                                      : 3'($urandom_range(0, NUM_SENSORS - 1));
    case ($urandom_range(0, 7))
      0:       ang = '0;
      1:       ang = '1;
      default: ang = ANGLE_BITS'($urandom);
    endcase
    send_reading(idx, ang, $urandom_range(0, 4) == 0);
  endtask

  // A frame that must be dropped: wrong checksum or unknown command.
  task automatic broken_frame();
    logic [7:0] op;
    op = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(OP_CALIBRATE, OP_READ))
                                     : 8'($urandom);
    if ($urandom_range(0, 1) == 0 && op != OP_CALIBRATE && op != OP_READ) begin
      send_frame(op, op);
    end else begin
      send_frame(op, op ^ 8'($urandom_range(1, 255)));
    end
  endtask

  initial begin
    int sel;
    sb              = new();
    items_sent      = 0;
    burst_left      = 0;
    quiet_cycles    = 0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_cmd          = 1'b0;
    in_rx_byte      = '0;
    in_sensor_index = '0;
    in_angle        = '0;
    in_read_failed  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: field extremes, out-of-range sensors, each frame kind.
    send_reading(3'd0, '0, 1'b0);
    send_reading(3'(NUM_SENSORS - 1), '1, 1'b0);
    send_reading(3'd2, '1, 1'b1);
    send_reading(3'd6, '1, 1'b1);
    send_reading(3'd7, '1, 1'b0);
    send_byte(8'h55);
    send_frame(OP_READ, OP_READ);
    // Sensor 2 still failed, so calibrate sets its flag again.
    send_frame(OP_CALIBRATE, OP_CALIBRATE);
    send_reading(3'd1, 14'd100, 1'b0);
    send_frame(OP_READ, OP_READ);
    send_frame(8'h03, 8'h03);
    send_frame(OP_READ, 8'hFF);
    send_frame(OP_READ, OP_READ);
    wait_drained();

    // Random part: mostly well-formed frames and readings, some noise.
    while (items_sent < TOTAL_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        random_reading();
      end else if (sel < 65) begin
        send_frame(OP_READ, OP_READ);
      end else if (sel < 80) begin
        send_frame(OP_CALIBRATE, OP_CALIBRATE);
      end else if (sel < 92) begin
        broken_frame();
      end else begin
        send_byte(8'($urandom));
      end
      if ($urandom_range(0, 29) == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("PASS angle_sensor_command_responder_core");
    end else begin
      $display("FAIL angle_sensor_command_responder_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ascr_pkg.sv
hw/rtl/ascr_ram.sv
hw/rtl/ascr_framer.sv
hw/rtl/angle_sensor_command_responder_core.sv
tb/tb.sv
